/* design/metaball_pixel_shader_defines.svh */
// Assertion macros for the metaball pixel shader.
`ifndef METABALL_PIXEL_SHADER_DEFINES_SVH
`define METABALL_PIXEL_SHADER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MPS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mps check failed");
`define MPS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("mps check failed");
`else
`define MPS_ASSERT(label, clk, rst_n, prop)
`define MPS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* design/mps_pkg.sv */
// Shared types and constants for the metaball pixel shader.
package mps_pkg;
	localparam int NUM_W = 30;                       // 50*255 << 16 fits 30 bits
	localparam int SUM_W = 20;                       // Q12.8 field sum
	localparam logic [SUM_W-1:0] Q_MAX = 20'hFFFFF;
	localparam logic [13:0] FIELD_GAIN = 14'd50;
	localparam logic [SUM_W-1:0] SAT_THRESHOLD = 20'd65280; // 255*256
	localparam logic [7:0] SAT_RED = 8'd255;
	localparam logic [7:0] SAT_GREEN = 8'd150;
	localparam logic [7:0] SAT_BLUE = 8'd220;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SHADE = 1'b1;

	typedef struct packed {
		logic wr;        // table write from the input beat
		logic start;     // latch pixel, clear sum and blob counter
		logic fetch;     // read entry, form dx/dy
		logic square;    // dx^2+dy^2, seed square root
		logic sqrt_step; // one root bit
		logic div_init;  // seed divider numerator
		logic div_step;  // one quotient bit
		logic accum;     // add term, advance blob
		logic emit;      // load output register
	} cmd_t;

	typedef struct packed {
		logic last_blob;
		logic out_busy;
	} stat_t;
endpackage

/* design/mps_if.sv */
// Input and output channel interfaces.
interface mps_in_if #(parameter int COORD_BITS = 10);
	logic valid;
	logic ready;
	logic operation;
	logic [1:0] blob_index;
	logic [COORD_BITS-1:0] coord_x;
	logic [COORD_BITS-1:0] coord_y;
	logic [7:0] radius;
	modport source (output valid, operation, blob_index, coord_x, coord_y, radius,
		input ready);
	modport sink (input valid, operation, blob_index, coord_x, coord_y, radius,
		output ready);
endinterface

interface mps_out_if;
	logic valid;
	logic ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

/* design/mps_ctrl.sv */
// Sequencer for the metaball shader: fetch, square, root, divide, accumulate.
`include "metaball_pixel_shader_defines.svh"
module mps_ctrl #(
	parameter int ROOT_W = 19
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_operation,
	output logic in_ready,
	input  logic out_ready,
	input  mps_pkg::stat_t stat,
	output mps_pkg::cmd_t cmd
);
	import mps_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_FETCH = 3'd1, ST_SQUARE = 3'd2,
		ST_SQRT = 3'd3, ST_DIV = 3'd4, ST_ACC = 3'd5, ST_EMIT = 3'd6;

	logic [2:0] state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_operation == OP_SHADE) begin
						cmd.start = 1'b1;
						state_d = ST_FETCH;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				cnt_d = CNT_W'(ROOT_W - 1);
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == '0) begin
					cmd.div_init = 1'b1;
					cnt_d = CNT_W'(NUM_W - 1);
					state_d = ST_DIV;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) state_d = ST_ACC;
				else cnt_d = cnt_q - 1'b1;
			end
			ST_ACC: begin
				cmd.accum = 1'b1;
				state_d = stat.last_blob ? ST_EMIT : ST_FETCH;
			end
			ST_EMIT: begin
				if (!stat.out_busy || out_ready) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	`MPS_ASSERT(a_emit_free, clk, arst_n, cmd.emit |-> (!stat.out_busy || out_ready))
	`MPS_ASSERT(a_ready_idle, clk, arst_n, in_ready |-> !(cmd.sqrt_step || cmd.div_step))
	`MPS_ASSERT_NEXT(a_start_fetch, clk, arst_n, cmd.start, cmd.fetch)
	`MPS_ASSERT_NEXT(a_sqrt_to_div, clk, arst_n, cmd.div_init, cmd.div_step)
endmodule

/* design/mps_datapath.sv */
// Blob table, square root, divider, accumulator and output register.
module mps_datapath #(
	parameter int BLOB_COUNT = 4,
	parameter int COORD_BITS = 10,
	parameter int ROOT_W = 19
) (
	input  logic clk,
	input  logic arst_n,
	input  mps_pkg::cmd_t cmd,
	output mps_pkg::stat_t stat,
	input  logic [1:0] blob_index,
	input  logic [COORD_BITS-1:0] coord_x,
	input  logic [COORD_BITS-1:0] coord_y,
	input  logic [7:0] radius,
	input  logic out_ready,
	output logic out_valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	import mps_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int SQ_W = 2 * CW + 1;
	localparam int SQRT_IN = 2 * ROOT_W;
	localparam int BI_W = (BLOB_COUNT > 1) ? $clog2(BLOB_COUNT) : 1;

	logic [CW-1:0] tab_x_q [BLOB_COUNT];
	logic [CW-1:0] tab_y_q [BLOB_COUNT];
	logic [7:0] tab_r_q [BLOB_COUNT];

	logic [CW-1:0] px_q, py_q, dx_q, dy_q;
	logic [7:0] rad_q;
	logic [BI_W-1:0] blob_q;
	logic [SQRT_IN-1:0] v_q;
	logic [ROOT_W+1:0] srem_q;
	logic [ROOT_W-1:0] root_q;
	logic [NUM_W-1:0] num_q, quo_q;
	logic [ROOT_W:0] drem_q;
	logic [SUM_W-1:0] sum_q;
	logic out_valid_q;
	logic [7:0] red_q, green_q, blue_q;

	// table: flops, cleared at reset
	for (genvar i = 0; i < BLOB_COUNT; i++) begin : g_tab
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tab_x_q[i] <= '0;
				tab_y_q[i] <= '0;
				tab_r_q[i] <= '0;
			end else if (cmd.wr && int'(blob_index) == i) begin
				tab_x_q[i] <= coord_x;
				tab_y_q[i] <= coord_y;
				tab_r_q[i] <= radius;
			end
		end
	end

	logic [CW-1:0] ex, ey;
	logic [SQ_W-1:0] sq;
	logic [ROOT_W+1:0] s_sh, s_trial;
	logic [ROOT_W:0] d_sh;
	logic [SUM_W-1:0] term;
	logic [SUM_W:0] sum_ext;
	logic [7:0] whole;
	logic [15:0] div5;

	always_comb begin
		ex = tab_x_q[blob_q];
		ey = tab_y_q[blob_q];
		sq = SQ_W'(dx_q * dx_q) + SQ_W'(dy_q * dy_q);
		s_sh = {srem_q[ROOT_W-1:0], v_q[SQRT_IN-1 -: 2]};
		s_trial = {root_q, 2'b01};
		d_sh = {drem_q[ROOT_W-1:0], num_q[NUM_W-1]};
		if (rad_q == '0) term = '0;
		else if (root_q == '0) term = Q_MAX;
		else if (quo_q > NUM_W'(Q_MAX)) term = Q_MAX;
		else term = quo_q[SUM_W-1:0];
		sum_ext = {1'b0, sum_q} + {1'b0, term};
		whole = sum_q[15:8];
		div5 = 16'(whole * 8'd205);     // floor(x/5) for 8-bit x
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (cmd.fetch) begin
			dx_q <= (px_q >= ex) ? px_q - ex : ex - px_q;
			dy_q <= (py_q >= ey) ? py_q - ey : ey - py_q;
			rad_q <= tab_r_q[blob_q];
		end
		if (cmd.square) begin
			v_q <= SQRT_IN'({sq, 16'b0});
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			v_q <= {v_q[SQRT_IN-3:0], 2'b00};
			if (s_sh >= s_trial) begin
				srem_q <= s_sh - s_trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= s_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			num_q <= NUM_W'(rad_q * FIELD_GAIN) << 16;
			drem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (d_sh >= {1'b0, root_q}) begin
				drem_q <= d_sh - {1'b0, root_q};
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				drem_q <= d_sh;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
		if (cmd.start) sum_q <= '0;
		else if (cmd.accum) sum_q <= sum_ext[SUM_W] ? Q_MAX : sum_ext[SUM_W-1:0];
		if (cmd.emit) begin
			if (sum_q > SAT_THRESHOLD) begin
				red_q <= SAT_RED;
				green_q <= SAT_GREEN;
				blue_q <= SAT_BLUE;
			end else begin
				red_q <= whole;
				green_q <= {2'b00, div5[15:10]};
				blue_q <= whole;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blob_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) blob_q <= '0;
			else if (cmd.accum) blob_q <= blob_q + 1'b1;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign stat.last_blob = (int'(blob_q) == BLOB_COUNT - 1);
	assign stat.out_busy = out_valid_q;
	assign out_valid = out_valid_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;
endmodule

/* design/metaball_pixel_shader.sv */
// Metaball pixel shader: blob table load and field-sum pixel coloring.
// A load beat is taken while the sequencer is idle and writes the blob table.
// A pixel beat runs, per blob, a fetch, a square, a root (ROOT_W steps), a 30-step divider
// and an accumulate, then emits its color; the next beat is taken only after that emit,
// which waits while the previous color sits unread.
// Reset clears the blob table, the sequencer and the output valid flag.
module metaball_pixel_shader #(
	parameter int BLOB_COUNT = 4,
	parameter int COORD_BITS = 10
) (
	input logic clk,
	input logic arst_n,
	mps_in_if.sink pix_in,
	mps_out_if.source pix_out
);
	import mps_pkg::*;

	// root of (dx^2+dy^2)<<16, one result bit per step
	localparam int ROOT_W = (2 * COORD_BITS + 1 + 16 + 1) / 2;

	cmd_t cmd;
	stat_t stat;

	// controller only steers; all arithmetic sits in the datapath
	mps_ctrl #(.ROOT_W(ROOT_W)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pix_in.valid),
		.in_operation(pix_in.operation),
		.in_ready(pix_in.ready),
		.out_ready(pix_out.ready),
		.stat(stat),
		.cmd(cmd)
	);

	// the output register holds a finished color while the next beat is taken
	mps_datapath #(
		.BLOB_COUNT(BLOB_COUNT),
		.COORD_BITS(COORD_BITS),
		.ROOT_W(ROOT_W)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.blob_index(pix_in.blob_index),
		.coord_x(pix_in.coord_x),
		.coord_y(pix_in.coord_y),
		.radius(pix_in.radius),
		.out_ready(pix_out.ready),
		.out_valid(pix_out.valid),
		.red(pix_out.red),
		.green(pix_out.green),
		.blue(pix_out.blue)
	);
endmodule

/* tb/sv/metaball_pixel_shader_test.sv */
// Self-checking testbench for the metaball pixel shader: blob loads and pixel shading.
module metaball_pixel_shader_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mps_pkg::*;

	localparam int BLOBS = 4;
	localparam int CBITS = 10;
	localparam int RANDOM_BEATS = 1800;
	// room for every pixel's shading plus stalls and gaps many times over
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	// one stimulus beat, with an optional color read off by hand
	typedef struct {
		logic op;
		logic [1:0] idx;
		logic [CBITS-1:0] x;
		logic [CBITS-1:0] y;
		logic [7:0] rad;
		bit typed;
		color_t want;
	} beat_t;

	logic clk;
	logic arst_n;

	mps_in_if #(.COORD_BITS(CBITS)) pix_in_ch();
	mps_out_if pix_out_ch();

	metaball_pixel_shader #(.BLOB_COUNT(BLOBS), .COORD_BITS(CBITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix_in_ch),
		.pix_out(pix_out_ch)
	);

	// our own copy of the blob table
	logic [CBITS-1:0] tbl_x [BLOBS];
	logic [CBITS-1:0] tbl_y [BLOBS];
	logic [7:0] tbl_rad [BLOBS];

	color_t colors_due [$];
	int errors = 0;
	longint cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("metaball_pixel_shader_test: FAIL");
			$finish;
		end
	end

	function automatic longint unsigned root_q8(input longint unsigned v);
		longint unsigned acc;
		longint unsigned trial;
		acc = 0;
		// largest root is about 2^19, so 21 bits cover it
		for (int b = 20; b >= 0; b--) begin
			trial = acc | (longint'(1) << b);
			if (trial * trial <= v)
				acc = trial;
		end
		return acc;
	endfunction

	// field sum over the table, then the color mapping
	function automatic color_t shade_color(input logic [CBITS-1:0] px,
		input logic [CBITS-1:0] py);
		longint unsigned sum;
		longint unsigned dx;
		longint unsigned dy;
		longint unsigned root_d;
		longint unsigned term;
		color_t c;
		sum = 0;
		for (int i = 0; i < BLOBS; i++) begin
			if (tbl_rad[i] == 0)
				continue;     // empty blob adds nothing, even on top of the pixel
			dx = 64'((px >= tbl_x[i]) ? px - tbl_x[i] : tbl_x[i] - px);
			dy = 64'((py >= tbl_y[i]) ? py - tbl_y[i] : tbl_y[i] - py);
			root_d = root_q8((dx * dx + dy * dy) << 16);
			if (root_d == 0)
				term = 64'(Q_MAX);  // pixel right on the center
			else
				term = (longint'(50) * tbl_rad[i] * 65536) / root_d;
			if (term > Q_MAX)
				term = 64'(Q_MAX);
			sum += term;
			if (sum > Q_MAX)
				sum = 64'(Q_MAX);
		end
		if (sum > SAT_THRESHOLD) begin
			c.red = SAT_RED;
			c.green = SAT_GREEN;
			c.blue = SAT_BLUE;
		end else begin
			c.red = sum[15:8];
			c.green = 8'(sum / 1280);
			c.blue = sum[15:8];
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
	endtask

	// called at the edge that takes a beat: updates the table or queues a color
	task automatic take_beat(input beat_t b);
		if (b.op == OP_LOAD) begin
			tbl_x[b.idx] = b.x;
			tbl_y[b.idx] = b.y;
			tbl_rad[b.idx] = b.rad;
		end else if (b.typed) begin
			colors_due = {colors_due, b.want};
		end else begin
			colors_due = {colors_due, shade_color(b.x, b.y)};
		end
	endtask

	// receiver: check each taken color, stall on a changing duty pattern
	int ready_pct = 100;
	int pattern_left = 0;
	always @(posedge clk) begin
		color_t want;
		if (arst_n && pix_out_ch.valid && pix_out_ch.ready) begin
			if (colors_due.size() == 0) begin
				report_mismatch("unexpected color beat", 0, 0);
			end else begin
				want = colors_due.pop_front();
				if (pix_out_ch.red !== want.red)
					report_mismatch("red", int'(pix_out_ch.red), int'(want.red));
				if (pix_out_ch.green !== want.green)
					report_mismatch("green", int'(pix_out_ch.green), int'(want.green));
				if (pix_out_ch.blue !== want.blue)
					report_mismatch("blue", int'(pix_out_ch.blue), int'(want.blue));
			end
		end
		if (pattern_left == 0) begin
			pattern_left = $urandom_range(20, 600);
			case ($urandom_range(0, 3))
				0: ready_pct = 100;
				1: ready_pct = 70;
				2: ready_pct = 25;
				default: ready_pct = 5;
			endcase
		end
		pattern_left--;
		pix_out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
	end

	// sender state: bursts of random length, random gaps
	int burst_left = 0;

	task automatic send_beat(input beat_t b);
		if (burst_left == 0) begin
			pix_in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 300)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		pix_in_ch.valid <= 1'b1;
		pix_in_ch.operation <= b.op;
		pix_in_ch.blob_index <= b.idx;
		pix_in_ch.coord_x <= b.x;
		pix_in_ch.coord_y <= b.y;
		pix_in_ch.radius <= b.rad;
		@(posedge clk);
		while (!pix_in_ch.ready) @(posedge clk);
		take_beat(b);
		burst_left--;
		// valid stays high into the next beat unless a gap follows
		if (burst_left == 0)
			pix_in_ch.valid <= 1'b0;
	endtask

	function automatic beat_t mk(input logic op, input int idx,
		input int x, input int y, input int rad, input int typed = 0,
		input color_t want = '0);
		beat_t b;
		b.op = op;
		b.idx = idx[1:0];
		b.x = x[CBITS-1:0];
		b.y = y[CBITS-1:0];
		b.rad = rad[7:0];
		b.typed = (typed != 0);
		b.want = want;
		return b;
	endfunction

	// random beat: mostly pixels, loads now and then with a mix of radii
	function automatic beat_t rand_beat();
		int r;
		int i;
		if ($urandom_range(0, 99) < 15) begin
			case ($urandom_range(0, 4))
				0: r = 0;
				1, 2: r = $urandom_range(1, 8);
				3: r = $urandom_range(1, 40);
				default: r = $urandom_range(0, 255);
			endcase
			return mk(OP_LOAD, $urandom_range(0, 3), $urandom_range(0, 1023),
				$urandom_range(0, 1023), r);
		end
		// pixel: half near a blob center, half anywhere; junk in ignored fields
		i = $urandom_range(0, BLOBS - 1);
		if ($urandom_range(0, 1))
			return mk(OP_SHADE, $urandom_range(0, 3),
				(tbl_x[i] + $urandom_range(0, 60) + 1024 - 30) % 1024,
				(tbl_y[i] + $urandom_range(0, 60) + 1024 - 30) % 1024,
				$urandom_range(0, 255));
		return mk(OP_SHADE, $urandom_range(0, 3), $urandom_range(0, 1023),
			$urandom_range(0, 1023), $urandom_range(0, 255));
	endfunction

	beat_t directed [$];

	task automatic add_row(input beat_t b);
		directed = {directed, b};
	endtask

	initial begin
		color_t dark;
		color_t hot;
		dark = '0;
		hot = {SAT_RED, SAT_GREEN, SAT_BLUE};
		arst_n = 1'b0;
		pix_in_ch.valid = 1'b0;
		pix_in_ch.operation = OP_LOAD;
		pix_in_ch.blob_index = '0;
		pix_in_ch.coord_x = '0;
		pix_in_ch.coord_y = '0;
		pix_in_ch.radius = '0;
		pix_out_ch.ready = 1'b0;
		for (int i = 0; i < BLOBS; i++) begin
			tbl_x[i] = '0;
			tbl_y[i] = '0;
			tbl_rad[i] = '0;
		end

		// empty table after reset: black everywhere, even on the zero centers
		add_row(mk(OP_SHADE, 0, 0, 0, 0, 1, dark));
		add_row(mk(OP_SHADE, 3, 1023, 1023, 255, 1, dark));
		// biggest blob, pixel on its center: saturated color
		add_row(mk(OP_LOAD, 0, 100, 100, 255));
		add_row(mk(OP_SHADE, 0, 100, 100, 0, 1, hot));
		add_row(mk(OP_SHADE, 1, 1023, 1023, 0));
		add_row(mk(OP_SHADE, 2, 0, 0, 0));
		// zero-radius blob under the pixel adds nothing
		add_row(mk(OP_LOAD, 0, 0, 0, 0));
		add_row(mk(OP_LOAD, 1, 0, 0, 0));
		add_row(mk(OP_SHADE, 0, 0, 0, 0, 1, dark));
		// smallest radius at the far corner, seen from the other corner
		add_row(mk(OP_LOAD, 3, 1023, 1023, 1));
		add_row(mk(OP_SHADE, 0, 0, 0, 0));
		add_row(mk(OP_SHADE, 0, 1023, 1022, 0));
		add_row(mk(OP_SHADE, 0, 1023, 1023, 0, 1, hot));
		// all four entries, mid-range sums
		add_row(mk(OP_LOAD, 0, 512, 512, 3));
		add_row(mk(OP_LOAD, 1, 341, 682, 2));
		add_row(mk(OP_LOAD, 2, 682, 341, 170));
		add_row(mk(OP_SHADE, 3, 500, 500, 85));
		add_row(mk(OP_SHADE, 0, 600, 400, 0));
		add_row(mk(OP_SHADE, 1, 512, 540, 0));
		add_row(mk(OP_SHADE, 2, 682, 341, 0, 1, hot));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k])
			send_beat(directed[k]);
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			// one full drain partway through
			if (n == RANDOM_BEATS / 2) begin
				pix_in_ch.valid <= 1'b0;
				burst_left = 0;
				while (colors_due.size() != 0) @(posedge clk);
				repeat (20) @(posedge clk);
			end
			send_beat(rand_beat());
		end
		pix_in_ch.valid <= 1'b0;

		while (colors_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("metaball_pixel_shader_test: PASS");
		else
			$display("metaball_pixel_shader_test: FAIL");
		$finish;
	end
endmodule

/* sim.f */
+incdir+design
design/mps_pkg.sv
design/mps_if.sv
design/mps_ctrl.sv
design/mps_datapath.sv
design/metaball_pixel_shader.sv
tb/sv/metaball_pixel_shader_test.sv
